// ===== sv/ircfcp_pkg.sv =====
// ----------------------------------------------------------------------------
// ircfcp_pkg
// Shared types and constants for the colour and formatting code parser.
// ----------------------------------------------------------------------------
`default_nettype none

package ircfcp_pkg;

  // Control and syntax bytes
  localparam logic [7:0] CH_RESET  = 8'h0F;
  localparam logic [7:0] CH_BOLD   = 8'h02;
  localparam logic [7:0] CH_UNDER  = 8'h1F;
  localparam logic [7:0] CH_COLOUR = 8'h03;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  // Colour widths and defaults
  localparam int unsigned COL_VAL_W      = 7;  // holds up to 99
  localparam int unsigned COL_OUT_W      = 4;
  localparam int unsigned NUM_COLORS_DEF = 16;
  localparam logic [COL_OUT_W-1:0] BG_DEFAULT = 4'd1;

  // Input stage contents
  typedef struct packed {
    logic       valid;
    logic [7:0] ch;
    logic       line_start;
  } in_item_t;

  // One result item, with a flag saying whether the byte produces one
  typedef struct packed {
    logic                 emit;
    logic [7:0]           ch;
    logic [COL_OUT_W-1:0] fg;
    logic [COL_OUT_W-1:0] bg;
    logic                 bold;
    logic                 underline;
  } result_t;

  // Parser attribute state
  typedef struct packed {
    logic                 bold;
    logic                 underline;
    logic                 fg_mode;
    logic                 bg_mode;
    logic [1:0]           digit_count;
    logic [COL_VAL_W-1:0] fg_value;
    logic [COL_VAL_W-1:0] bg_value;
    logic                 bg_given;
  } attr_state_t;

endpackage

`default_nettype wire

// ===== sv/irc_format_code_parser_unit.sv =====
// ----------------------------------------------------------------------------
// irc_format_code_parser_unit
// Colour and formatting code parser for chat text, one byte per cycle unless stalled.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall): one text byte with a line-start flag.
// Control bytes (reset, bold, underline, colour and its digits and comma)
// update the attributes and give no result; every other byte gives one
// result item on the output channel (out_valid / out_stall) carrying the
// byte with its foreground, background, bold and underline attributes.
// A byte accepted into the input register is decoded into the result register
// when it moves on, and out_valid then goes high if it gives a result.
// Throughput: one byte per cycle unless the receiver stalls; the attribute
// update is a single short decode between the input and result registers.
// Reset (rst_n low, synchronous) empties both registers and clears all
// attributes; a byte flagged as the start of a line also clears them.
// When the receiver stalls, the result register holds its item; bytes that
// give no result still move through, and a byte that gives a result waits
// in the input register, raising in_stall, until the result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module irc_format_code_parser_unit #(
  parameter int unsigned NUM_COLORS = ircfcp_pkg::NUM_COLORS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_char_in,
  input  wire logic       in_line_start,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_char_out,
  output logic [3:0]      out_fg_color,
  output logic [3:0]      out_bg_color,
  output logic            out_bold_on,
  output logic            out_underline_on
);

  ircfcp_pkg::in_item_t item;
  ircfcp_pkg::result_t  res;
  logic advance;
  logic out_load;
  logic out_valid_r, out_valid_nxt;
  logic [7:0] char_r;
  logic [3:0] fg_r, bg_r;
  logic       bold_r, underline_r;

  // Held byte moves on unless it needs the result slot and that is blocked
  assign advance  = item.valid & (~res.emit | ~out_valid_r | ~out_stall);
  assign out_load = advance & res.emit;

  ircfcp_in_reg u_in_reg (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_char_in    (in_char_in),
    .in_line_start (in_line_start),
    .advance       (advance),
    .in_stall      (in_stall),
    .item          (item)
  );

  ircfcp_parse #(
    .NUM_COLORS (NUM_COLORS)
  ) u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .item    (item),
    .advance (advance),
    .res     (res)
  );

  // Result register valid
  always_comb begin
    out_valid_nxt = out_valid_r & out_stall;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (out_load) begin
      char_r      <= res.ch;
      fg_r        <= res.fg;
      bg_r        <= res.bg;
      bold_r      <= res.bold;
      underline_r <= res.underline;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_char_out     = char_r;
  assign out_fg_color     = fg_r;
  assign out_bg_color     = bg_r;
  assign out_bold_on      = bold_r;
  assign out_underline_on = underline_r;

endmodule

`default_nettype wire

// ===== sv/ircfcp_in_reg.sv =====
// ----------------------------------------------------------------------------
// ircfcp_in_reg
// Input register: captures one item from the input channel and holds it
// until the parser stage moves it on.
// ----------------------------------------------------------------------------
`default_nettype none

module ircfcp_in_reg (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  input  wire logic [7:0]          in_char_in,
  input  wire logic                in_line_start,
  input  wire logic                advance,
  output logic                     in_stall,
  output ircfcp_pkg::in_item_t     item
);

  logic       valid_r, valid_nxt;
  logic [7:0] ch_r;
  logic       line_start_r;
  logic       load;

  // Held item blocks the channel until it is moved on
  assign in_stall = valid_r & ~advance;
  assign load     = in_valid & ~in_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (!in_stall) begin
      valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload, no reset needed
  always_ff @(posedge clk) begin
    if (load) begin
      ch_r         <= in_char_in;
      line_start_r <= in_line_start;
    end
  end

  assign item.valid      = valid_r;
  assign item.ch         = ch_r;
  assign item.line_start = line_start_r;

endmodule

`default_nettype wire

// ===== sv/ircfcp_parse.sv =====
// ----------------------------------------------------------------------------
// ircfcp_parse
// Attribute state and byte decode: updates bold, underline and colour
// state for the held byte and forms its result.
// ----------------------------------------------------------------------------
`default_nettype none

module ircfcp_parse #(
  parameter int unsigned NUM_COLORS = ircfcp_pkg::NUM_COLORS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire ircfcp_pkg::in_item_t item,
  input  wire logic                 advance,
  output ircfcp_pkg::result_t       res
);

  localparam logic [ircfcp_pkg::COL_VAL_W-1:0] NUM_COL_V =
    ircfcp_pkg::COL_VAL_W'(NUM_COLORS);

  ircfcp_pkg::attr_state_t st_r, st_nxt, cur;
  logic       is_digit;
  logic [3:0] digit;
  logic       emit;
  logic [ircfcp_pkg::COL_VAL_W+3:0] fg_acc, bg_acc;
  logic [ircfcp_pkg::COL_VAL_W-1:0] bg_raw;

  assign is_digit = (item.ch >= ircfcp_pkg::CH_ZERO) && (item.ch <= ircfcp_pkg::CH_NINE);
  assign digit    = 4'(item.ch - ircfcp_pkg::CH_ZERO);

  // value * 10 + digit, kept to colour width
  assign fg_acc = {1'b0, cur.fg_value, 3'b000} + {3'b000, cur.fg_value, 1'b0} + 11'(digit);
  assign bg_acc = {1'b0, cur.bg_value, 3'b000} + {3'b000, cur.bg_value, 1'b0} + 11'(digit);

  // Decode and next state
  always_comb begin
    cur    = item.line_start ? '0 : st_r;
    st_nxt = cur;
    emit   = 1'b0;
    if (item.ch == ircfcp_pkg::CH_RESET) begin
      st_nxt = '0;
    end else if (item.ch == ircfcp_pkg::CH_BOLD) begin
      st_nxt.bold = ~cur.bold;
    end else if (item.ch == ircfcp_pkg::CH_UNDER) begin
      st_nxt.underline = ~cur.underline;
    end else if (item.ch == ircfcp_pkg::CH_COLOUR) begin
      st_nxt.fg_mode     = 1'b1;
      st_nxt.digit_count = 2'd0;
      st_nxt.fg_value    = '0;
      st_nxt.bg_value    = '0;
      st_nxt.bg_given    = 1'b0;
    end else if (cur.fg_mode && is_digit && cur.digit_count < 2'd2) begin
      st_nxt.digit_count = cur.digit_count + 2'd1;
      st_nxt.fg_value    = fg_acc[ircfcp_pkg::COL_VAL_W-1:0];
    end else if (cur.fg_mode && item.ch == ircfcp_pkg::CH_COMMA) begin
      st_nxt.digit_count = 2'd0;
      st_nxt.bg_mode     = 1'b1;
      st_nxt.fg_mode     = 1'b0;
    end else if (cur.bg_mode && is_digit && cur.digit_count < 2'd2) begin
      st_nxt.digit_count = cur.digit_count + 2'd1;
      st_nxt.bg_value    = bg_acc[ircfcp_pkg::COL_VAL_W-1:0];
      st_nxt.bg_given    = 1'b1;
    end else begin
      // ordinary byte closes any colour code and is passed through
      st_nxt.digit_count = 2'd0;
      st_nxt.fg_mode     = 1'b0;
      st_nxt.bg_mode     = 1'b0;
      emit               = 1'b1;
    end
  end

  // Result fields from the state seen by this byte
  assign bg_raw = cur.bg_given ? cur.bg_value
                               : ircfcp_pkg::COL_VAL_W'(ircfcp_pkg::BG_DEFAULT);
  assign res.emit = emit;
  assign res.ch   = item.ch;
  assign res.fg = (cur.fg_value >= NUM_COL_V) ? '0
                                              : cur.fg_value[ircfcp_pkg::COL_OUT_W-1:0];
  assign res.bg = (bg_raw >= NUM_COL_V) ? '0 : bg_raw[ircfcp_pkg::COL_OUT_W-1:0];
  assign res.bold      = cur.bold;
  assign res.underline = cur.underline;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (advance) begin
      st_r <= st_nxt;
    end
  end

endmodule

`default_nettype wire
